// File: rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic RESULT_HEADER  = 1'b0;
  localparam logic RESULT_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    TOK_HDR0,
    TOK_HDR1,
    TOK_EXT,
    TOK_KEY,
    TOK_PAYLOAD
  } tok_op_t;

  typedef struct packed {
    tok_op_t    op;
    logic [7:0] data;
    logic       emit;
    logic       last;
  } tok_t;

endpackage

// File: rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// WebSocket frame deframer: header decode and payload byte pass-through.
// ----------------------------------------------------------------------------
// Takes one stream byte per item and sustains one item per cycle while the
// result port does not stall. A header result appears on the byte that
// completes the header, a payload result on every payload byte (passed on as
// received, not unmasked); header bytes before the last give no result. The
// classifier and the result builder are parted by a QueueDepth-entry token
// queue, and each result is held in an output register; stream_stall rises
// only once the queue has filled behind a stalled result port.
module websocket_frame_deframer_top #(
  parameter int QueueDepth = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic        final_fragment,
  output logic [2:0]  reserved_bits,
  output logic [3:0]  frame_opcode,
  output logic        is_masked,
  output logic [31:0] masking_key,
  output logic [63:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        frame_end
);
  import wsfd_pkg::*;

  logic tok_in_valid;
  tok_t tok_in;
  logic q_full;
  logic q_pop;
  logic q_valid;
  tok_t q_tok;

  wsfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stream_valid),
    .in_stall  (stream_stall),
    .in_byte   (stream_byte),
    .tok_valid (tok_in_valid),
    .tok       (tok_in),
    .tok_full  (q_full)
  );

  wsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (tok_in_valid),
    .push_tok   (tok_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_tok   (q_tok)
  );

  wsfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (q_valid),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .out_valid  (result_valid),
    .out_stall  (result_stall),
    .out_kind   (result_kind),
    .out_fin    (final_fragment),
    .out_rsv    (reserved_bits),
    .out_opcode (frame_opcode),
    .out_masked (is_masked),
    .out_key    (masking_key),
    .out_length (frame_length),
    .out_byte   (payload_byte),
    .out_end    (frame_end)
  );

endmodule

// File: rtl/wsfd_front.sv
// ----------------------------------------------------------------------------
// wsfd_front
// Byte classifier: tracks the frame phase and lengths, tags each byte.
// ----------------------------------------------------------------------------
module wsfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  output logic          tok_valid,
  output wsfd_pkg::tok_t tok,
  input  logic          tok_full
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  count, count_next;
  logic        masked, masked_next;
  logic [63:0] length, length_next;
  logic [63:0] remaining, remaining_next;
  logic        accept;
  logic [63:0] len_shift;
  logic        emit;
  logic        last;
  tok_op_t     op;

  assign in_stall  = tok_full;
  assign accept    = in_valid && !tok_full;
  assign len_shift = {length[55:0], in_byte};

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    masked_next    = masked;
    length_next    = length;
    remaining_next = remaining;
    emit           = 1'b0;
    last           = 1'b0;
    op             = TOK_HDR0;
    unique case (phase) inside
      PH_HDR0: begin
        op          = TOK_HDR0;
        length_next = '0;
        masked_next = 1'b0;
        count_next  = '0;
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        op          = TOK_HDR1;
        masked_next = in_byte[7];
        count_next  = '0;
        if (in_byte[6:0] == LEN_CODE_16) begin
          phase_next = PH_EXT16;
        end else if (in_byte[6:0] == LEN_CODE_64) begin
          phase_next = PH_EXT64;
        end else begin
          length_next = {57'd0, in_byte[6:0]};
          if (in_byte[7]) begin
            phase_next = PH_KEY;
          end else begin
            emit           = 1'b1;
            last           = (in_byte[6:0] == 7'd0);
            remaining_next = {57'd0, in_byte[6:0]};
            phase_next     = last ? PH_HDR0 : PH_PAYLOAD;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        op          = TOK_EXT;
        length_next = len_shift;
        count_next  = count + 3'd1;
        if ((phase == PH_EXT16 && count == 3'd1) || (phase == PH_EXT64 && count == 3'd7)) begin
          count_next = '0;
          if (masked) begin
            phase_next = PH_KEY;
          end else begin
            emit           = 1'b1;
            last           = (len_shift == 64'd0);
            remaining_next = len_shift;
            phase_next     = last ? PH_HDR0 : PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        op         = TOK_KEY;
        count_next = count + 3'd1;
        if (count == 3'd3) begin
          count_next     = '0;
          emit           = 1'b1;
          last           = (length == 64'd0);
          remaining_next = length;
          phase_next     = last ? PH_HDR0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        op             = TOK_PAYLOAD;
        emit           = 1'b1;
        last           = (remaining == 64'd1);
        remaining_next = remaining - 64'd1;
        if (last) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      count     <= '0;
      masked    <= 1'b0;
      length    <= '0;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      count     <= count_next;
      masked    <= masked_next;
      length    <= length_next;
      remaining <= remaining_next;
    end
  end

  assign tok_valid = accept;
  assign tok.op    = op;
  assign tok.data  = in_byte;
  assign tok.emit  = emit;
  assign tok.last  = last;

endmodule

// File: rtl/wsfd_queue.sv
// ----------------------------------------------------------------------------
// wsfd_queue
// Short token queue between the classifier and the result builder.
// ----------------------------------------------------------------------------
module wsfd_queue #(
  parameter int Depth = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wsfd_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wsfd_pkg::tok_t head_tok
);
  import wsfd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tok_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full       = (fill == FullCnt);
  assign head_valid = (fill != '0);
  assign head_tok   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/wsfd_back.sv
// ----------------------------------------------------------------------------
// wsfd_back
// Result builder: assembles header fields from tokens, drives result items.
// ----------------------------------------------------------------------------
module wsfd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  input  wsfd_pkg::tok_t tok,
  output logic           tok_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_kind,
  output logic           out_fin,
  output logic [2:0]     out_rsv,
  output logic [3:0]     out_opcode,
  output logic           out_masked,
  output logic [31:0]    out_key,
  output logic [63:0]    out_length,
  output logic [7:0]     out_byte,
  output logic           out_end
);
  import wsfd_pkg::*;

  logic        fin, fin_next;
  logic [2:0]  rsv, rsv_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [31:0] key, key_next;
  logic [63:0] length, length_next;
  logic        out_free;
  logic        load;

  assign out_free = !out_valid || !out_stall;
  assign tok_pop  = tok_valid && (!tok.emit || out_free);
  assign load     = tok_pop && tok.emit;

  always_comb begin
    fin_next    = fin;
    rsv_next    = rsv;
    opcode_next = opcode;
    masked_next = masked;
    key_next    = key;
    length_next = length;
    unique case (tok.op)
      TOK_HDR0: begin
        fin_next    = tok.data[7];
        rsv_next    = tok.data[6:4];
        opcode_next = tok.data[3:0];
        masked_next = 1'b0;
        key_next    = '0;
        length_next = '0;
      end
      TOK_HDR1: begin
        masked_next = tok.data[7];
        if (tok.data[6:0] != LEN_CODE_16 && tok.data[6:0] != LEN_CODE_64) begin
          length_next = {57'd0, tok.data[6:0]};
        end
      end
      TOK_EXT:     length_next = {length[55:0], tok.data};
      TOK_KEY:     key_next = {key[23:0], tok.data};
      TOK_PAYLOAD: length_next = length;
      default:     length_next = length;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin    <= 1'b0;
      rsv    <= '0;
      opcode <= '0;
      masked <= 1'b0;
      key    <= '0;
      length <= '0;
    end else if (tok_pop) begin
      fin    <= fin_next;
      rsv    <= rsv_next;
      opcode <= opcode_next;
      masked <= masked_next;
      key    <= key_next;
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= (tok.op == TOK_PAYLOAD) ? RESULT_PAYLOAD : RESULT_HEADER;
      out_fin    <= fin_next;
      out_rsv    <= rsv_next;
      out_opcode <= opcode_next;
      out_masked <= masked_next;
      out_key    <= masked_next ? key_next : 32'd0;
      out_length <= length_next;
      out_byte   <= (tok.op == TOK_PAYLOAD) ? tok.data : 8'd0;
      out_end    <= tok.last;
    end
  end

endmodule
